FILE: hw/rtl/i2c_slave_multi_address_fsm_top_assert.svh
// Assertion macros for the I2C slave sequencer.
`ifndef I2C_SLAVE_MULTI_ADDRESS_FSM_TOP_ASSERT_SVH
`define I2C_SLAVE_MULTI_ADDRESS_FSM_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define I2CSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2c slave sequencer: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define I2CSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2c slave sequencer: next-cycle check failed");

`endif

FILE: hw/rtl/i2csm_pkg.sv
// Types, codes and helper functions for the I2C slave sequencer.
package i2csm_pkg;

  localparam int NUM_ADDRESSES = 3;

  // Bus event kinds
  localparam logic [1:0] KIND_START      = 2'd0;
  localparam logic [1:0] KIND_START_STOP = 2'd1;
  localparam logic [1:0] KIND_SHIFT_DONE = 2'd2;

  // Phase codes reported to the shift unit
  localparam logic [2:0] OUT_IDLE      = 3'd0;
  localparam logic [2:0] OUT_SEND_ACK  = 3'd1;
  localparam logic [2:0] OUT_SEND_BYTE = 3'd2;
  localparam logic [2:0] OUT_RECV_BYTE = 3'd3;
  localparam logic [2:0] OUT_RECV_ACK  = 3'd4;
  localparam logic [2:0] OUT_RECV_ADDR = 3'd5;

  localparam logic [1:0] NO_SLAVE = 2'd3;

  typedef enum logic [6:0] {
    PH_ADDR     = 7'b0000001,
    PH_PREP_SND = 7'b0000010,
    PH_PREP_RCV = 7'b0000100,
    PH_SND      = 7'b0001000,
    PH_RCV      = 7'b0010000,
    PH_RCVPROC  = 7'b0100000,
    PH_RCV_ACK  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0] next_phase;
    logic       sda_pull;
    logic [7:0] shift_load;
    logic       tx_taken;
    logic       rx_valid;
    logic [7:0] rx_byte_out;
    logic       first_after_start;
    logic [1:0] active_slave;
  } res_t;

  // Phase code seen by the shift unit
  function automatic logic [2:0] phase_code(input logic listening, input phase_t ph);
    logic [2:0] code;
    code = OUT_IDLE;
    if (listening) begin
      unique case (ph)
        PH_ADDR:     code = OUT_RECV_ADDR;
        PH_PREP_SND: code = OUT_SEND_ACK;
        PH_PREP_RCV: code = OUT_SEND_ACK;
        PH_SND:      code = OUT_SEND_BYTE;
        PH_RCV:      code = OUT_RECV_BYTE;
        PH_RCVPROC:  code = OUT_SEND_ACK;
        PH_RCV_ACK:  code = OUT_RECV_ACK;
        default:     code = OUT_IDLE;
      endcase
    end
    return code;
  endfunction

  // Slave drives SDA in the ack and send phases
  function automatic logic pull_code(input logic listening, input phase_t ph);
    return listening && (ph == PH_PREP_SND || ph == PH_PREP_RCV ||
                         ph == PH_SND || ph == PH_RCVPROC);
  endfunction

endpackage

FILE: hw/rtl/i2c_slave_multi_address_fsm_top.sv
// I2C slave sequencer with several own addresses, bus-event in, phase command out.
//
// Takes one bus event per cycle while in_stall is low (start, start-then-stop, or shift
// done) and returns one command for the shift unit per event: the next phase, whether
// the slave drives SDA, the value to load into the shift register, and the byte
// hand-off to the application. Each event is decoded in the cycle it is accepted; its
// command is registered into the output register, or into the skid entry while the
// output register is held. A one-entry skid buffer behind the output register lets
// one further event be taken while the downstream side stalls; in_stall rises only
// once that is full. Own addresses are written through cfg_we/cfg_index/cfg_data
// only while the block is idle, which the user must keep to, as the block does not
// enforce it; an address above 127 never matches.
module i2c_slave_multi_address_fsm_top (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // bus events
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [7:0] shift_data,
  input  logic [7:0] tx_byte,
  input  logic       keep_receiving,
  // commands
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] next_phase,
  output logic       sda_pull,
  output logic [7:0] shift_load,
  output logic       tx_taken,
  output logic       rx_valid,
  output logic [7:0] rx_byte_out,
  output logic       first_after_start,
  output logic [1:0] active_slave
);
  import i2csm_pkg::*;

`include "i2c_slave_multi_address_fsm_top_assert.svh"

  logic [7:0] slave_address [NUM_ADDRESSES];

  phase_t     phase, phase_next;
  logic       listening, listening_next;
  logic [1:0] matched_index, matched_index_next;
  logic [7:0] held_rx_byte, held_rx_byte_next;
  logic       start_pending, start_pending_next;

  res_t       res_new;
  res_t       out_res, skid_res;
  logic       skid_valid;

  logic       in_accept, out_take;
  logic [1:0] hit;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // Own address registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ADDRESSES; i++) begin
        slave_address[i] <= 8'hFF;
      end
    end else if (cfg_we && (32'(cfg_index) < NUM_ADDRESSES)) begin
      slave_address[cfg_index] <= cfg_data;
    end
  end

  // Address compare, lowest index wins
  always_comb begin
    hit = NO_SLAVE;
    for (int i = NUM_ADDRESSES - 1; i >= 0; i--) begin
      if (slave_address[i] == {1'b0, shift_data[7:1]}) begin
        hit = 2'(i);
      end
    end
  end

  // Advance the sequencer for one event
  always_comb begin
    phase_next         = phase;
    listening_next     = listening;
    matched_index_next = matched_index;
    held_rx_byte_next  = held_rx_byte;
    start_pending_next = start_pending;
    res_new            = '0;

    if (kind == KIND_START || kind == KIND_START_STOP) begin
      phase_next         = PH_ADDR;
      matched_index_next = NO_SLAVE;
      start_pending_next = 1'b1;
      listening_next     = (kind == KIND_START);
    end else if (kind == KIND_SHIFT_DONE && listening) begin
      unique case (phase)
        PH_ADDR: begin
          if (hit == NO_SLAVE) begin
            listening_next     = 1'b0;
            matched_index_next = NO_SLAVE;
          end else begin
            matched_index_next = hit;
            phase_next         = shift_data[0] ? PH_PREP_SND : PH_PREP_RCV;
          end
        end
        PH_RCV_ACK, PH_PREP_SND: begin
          if (phase == PH_RCV_ACK && shift_data[0]) begin
            // master NACK ends the transfer
            listening_next     = 1'b0;
            matched_index_next = NO_SLAVE;
          end else begin
            res_new.shift_load        = tx_byte;
            res_new.tx_taken          = 1'b1;
            res_new.first_after_start = start_pending;
            start_pending_next        = 1'b0;
            phase_next                = PH_SND;
          end
        end
        PH_PREP_RCV: phase_next = PH_RCV;
        PH_SND:      phase_next = PH_RCV_ACK;
        PH_RCV: begin
          held_rx_byte_next = shift_data;
          phase_next        = PH_RCVPROC;
        end
        PH_RCVPROC: begin
          res_new.rx_valid          = 1'b1;
          res_new.rx_byte_out       = held_rx_byte;
          res_new.first_after_start = start_pending;
          start_pending_next        = 1'b0;
          phase_next                = keep_receiving ? PH_RCV : PH_ADDR;
        end
        default: phase_next = PH_ADDR;
      endcase
    end

    res_new.next_phase   = phase_code(listening_next, phase_next);
    res_new.sda_pull     = pull_code(listening_next, phase_next);
    res_new.active_slave = matched_index_next;
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_ADDR;
      listening     <= 1'b0;
      matched_index <= NO_SLAVE;
      held_rx_byte  <= 8'h00;
      start_pending <= 1'b0;
    end else if (in_accept) begin
      phase         <= phase_next;
      listening     <= listening_next;
      matched_index <= matched_index_next;
      held_rx_byte  <= held_rx_byte_next;
      start_pending <= start_pending_next;
    end
  end

  // Output register and skid entry control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Output register and skid entry payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_res <= skid_res;
      end
    end else if (in_accept) begin
      if (out_valid && !out_take) begin
        skid_res <= res_new;
      end else begin
        out_res <= res_new;
      end
    end
  end

  assign next_phase        = out_res.next_phase;
  assign sda_pull          = out_res.sda_pull;
  assign shift_load        = out_res.shift_load;
  assign tx_taken          = out_res.tx_taken;
  assign rx_valid          = out_res.rx_valid;
  assign rx_byte_out       = out_res.rx_byte_out;
  assign first_after_start = out_res.first_after_start;
  assign active_slave      = out_res.active_slave;

  // A held skid entry implies a full output register
  `I2CSM_ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // Disarmed sequencer never keeps a matched slave
  `I2CSM_ASSERT_IMPLY(a_disarmed_no_match, clk, rst, !listening, matched_index == NO_SLAVE)
  // A command never both takes a tx byte and delivers an rx byte
  `I2CSM_ASSERT_IMPLY(a_one_handoff, clk, rst, out_valid, !(out_res.tx_taken && out_res.rx_valid))
  // Skid entry stays while downstream stalls
  `I2CSM_ASSERT_NEXT(a_skid_holds, clk, rst, skid_valid && out_stall, skid_valid)

endmodule
